// ===== hw/rtl/pseg_pkg.sv =====
// Shared constants for the polyline segment densifier.
// No dependencies; compiled first, used by the channel interfaces and the top level.

package pseg_pkg;

    // Width and reset value of the segment length register (1/64 m units).
    localparam int          LEN_BITS      = 20;
    localparam logic [19:0] MAX_LEN_RESET = 20'd5120;

    // Defaults for the top-level parameters.
    localparam int COORD_BITS_DEF = 32;
    localparam int MAX_SPLITS_DEF = 63;

    // Digit width of the shared shift-and-add multiplier.
    localparam int DIGIT_BITS = 16;

endpackage

// ===== hw/rtl/pseg_if.sv =====
// Valid/ready channel interfaces for vertices in and points out.
// Depends on pseg_pkg for the default coordinate width.

interface pseg_vertex_if
    import pseg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] vertex_x;
    logic [COORD_BITS-1:0] vertex_y;
    logic                  starts_line;

    modport source (output valid, output vertex_x, output vertex_y, output starts_line,
                    input ready);
    modport sink   (input valid, input vertex_x, input vertex_y, input starts_line,
                    output ready);
endinterface

interface pseg_point_if
    import pseg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic                  is_inserted;
    logic                  last_of_run;
    logic                  splits_clamped;

    modport source (output valid, output point_x, output point_y, output is_inserted,
                    output last_of_run, output splits_clamped, input ready);
    modport sink   (input valid, input point_x, input point_y, input is_inserted,
                    input last_of_run, input splits_clamped, output ready);
endinterface

// ===== hw/rtl/polyline_segment_densifier_top.sv =====
// Polyline segment densifier: splits long segments into evenly spaced points.
// Depends on pseg_pkg and on the channel interfaces in pseg_if.sv.
//
//   channel   direction  transfer moves
//   vertex    in         vertex_x, vertex_y, starts_line
//   point     out        point_x, point_y, is_inserted, last_of_run, splits_clamped
//   cfg_wr_*  in         segment length limit, written whenever cfg_wr_en is high
//
// A line-start vertex goes straight to the emit phase. Any other vertex takes a
// magnitude step, three squarings of 3 digits each on the shared 16-bit-digit
// multiplier and a compare step, then a split search on the shared adder and
// compare, a bit-serial division and a set-up step when points are inserted, and
// then one point per free output slot in the emit phase.
// Reset (rst_n, asynchronous) clears the previous vertex and the sequencer; no
// clearing pass is needed. A stalled point channel holds the sequencer in the
// emit phase; the vertex channel is ready only between items.

module polyline_segment_densifier_top
    import pseg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int MAX_SPLITS = MAX_SPLITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    pseg_vertex_if.sink         vertex,
    pseg_point_if.source        point,
    input  logic                cfg_wr_en,
    input  logic [LEN_BITS-1:0] cfg_wr_data
);

    // Derived widths.
    localparam int CB   = COORD_BITS;
    localparam int MAGW = CB + 1;
    localparam int MW   = (MAGW > LEN_BITS) ? MAGW : LEN_BITS;
    localparam int ND   = (MW + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int MPW  = ND * DIGIT_BITS;
    localparam int PW   = 2 * MW;
    localparam int DGW  = (ND > 1) ? $clog2(ND) : 1;
    localparam int SPW  = $clog2(MAX_SPLITS + 2);
    localparam int SQW  = 2 * LEN_BITS + 2 * SPW;
    localparam int CMPW = (PW + 1 > SQW) ? (PW + 1) : SQW;
    localparam int DVW  = CB + 2;
    localparam int DSW  = SPW + 1;
    localparam int DCW  = $clog2(DVW);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAG,
        S_SQ_X,
        S_SQ_Y,
        S_SQ_L,
        S_CHECK,
        S_SEARCH,
        S_DIVIDE,
        S_STEP,
        S_EMIT
    } state_t;

    // Control and output registers.
    state_t            state_reg, state_next;
    logic [LEN_BITS-1:0] max_len_reg, max_len_next;
    logic              have_prev_reg, have_prev_next;
    logic [CB-1:0]     prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic              out_valid_reg, out_valid_next;
    logic [CB-1:0]     out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic              out_ins_reg, out_ins_next, out_last_reg, out_last_next;
    logic              out_clamp_reg, out_clamp_next;
    logic [DGW-1:0]    dig_reg, dig_next;
    logic [DCW-1:0]    div_cnt_reg, div_cnt_next;
    logic [SPW-1:0]    t_reg, t_next, splits_reg, splits_next, k_reg, k_next;
    logic              clamped_reg, clamped_next;

    // Datapath registers.
    logic [CB-1:0]     cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [MAGW-1:0]   dx_reg, dx_next, dy_reg, dy_next;
    logic [MAGW-1:0]   mag_x_reg, mag_x_next, mag_y_reg, mag_y_next;
    logic              neg_x_reg, neg_x_next, neg_y_reg, neg_y_next;
    logic [MW-1:0]     mcand_reg, mcand_next;
    logic [MPW-1:0]    mplier_reg, mplier_next;
    logic [PW-1:0]     prod_reg, prod_next;
    logic [CMPW-1:0]   d2_reg, d2_next, l2_reg, l2_next, sq_reg, sq_next, inc_reg, inc_next;
    logic [DSW-1:0]    divisor_reg, divisor_next;
    logic [DVW-1:0]    dvd_x_reg, dvd_x_next, dvd_y_reg, dvd_y_next;
    logic [DSW-1:0]    rem_x_reg, rem_x_next, rem_y_reg, rem_y_next;
    logic [MAGW-1:0]   qx_reg, qx_next, qy_reg, qy_next;
    logic [DSW-1:0]    rx_reg, rx_next, ry_reg, ry_next;

    // Shared multiplier step: one 16-bit digit of the multiplier, most significant first.
    logic [DIGIT_BITS-1:0]    digit;
    logic [MW+DIGIT_BITS-1:0] part;
    logic [PW-1:0]            prod_step;
    logic                     last_digit;

    assign digit      = mplier_reg[MPW-1 -: DIGIT_BITS];
    assign part       = mcand_reg * digit;
    assign prod_step  = {prod_reg[PW-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}} + PW'(part);
    assign last_digit = (dig_reg == DGW'(ND - 1));

    // One restoring division step; quotient bits shift in at the bottom.
    function automatic logic [DVW+DSW-1:0] div_step(input logic [DVW-1:0] dvd,
                                                    input logic [DSW-1:0] rem,
                                                    input logic [DSW-1:0] dsr);
        logic [DSW:0]   trial;
        logic [DSW:0]   diff;
        logic           ge;
        logic [DSW-1:0] rem_n;
        trial = {rem, dvd[DVW-1]};
        diff  = trial - {1'b0, dsr};
        ge    = (trial >= {1'b0, dsr});
        rem_n = ge ? diff[DSW-1:0] : trial[DSW-1:0];
        return {dvd[DVW-2:0], ge, rem_n};
    endfunction

    // Advance the rounded quotient by one point: q += a, r += b, carry when r >= 2n.
    function automatic logic [MAGW+DSW-1:0] advance(input logic [MAGW-1:0] q,
                                                    input logic [DSW-1:0]  r,
                                                    input logic [MAGW-1:0] a,
                                                    input logic [DSW-1:0]  b,
                                                    input logic [DSW-1:0]  dsr);
        logic [DSW:0]    sum;
        logic [DSW:0]    diff;
        logic            c;
        logic [MAGW-1:0] q_n;
        logic [DSW-1:0]  r_n;
        sum  = {1'b0, r} + {1'b0, b};
        diff = sum - {1'b0, dsr};
        c    = (sum >= {1'b0, dsr});
        r_n  = c ? diff[DSW-1:0] : sum[DSW-1:0];
        q_n  = q + a + MAGW'(c);
        return {q_n, r_n};
    endfunction

    // Division and rounding lanes for the two axes.
    logic [DVW+DSW-1:0]  div_x, div_y;
    logic [MAGW+DSW-1:0] adv_x, adv_y;
    logic [MAGW-1:0]     mag_dx, mag_dy;
    logic [CB-1:0]       pt_x, pt_y;
    logic [DSW-1:0]      half_div;
    logic                slot_free;
    logic                accept;
    logic                start;
    logic [SPW-1:0]      n_val;

    assign div_x    = div_step(dvd_x_reg, rem_x_reg, divisor_reg);
    assign div_y    = div_step(dvd_y_reg, rem_y_reg, divisor_reg);
    assign adv_x    = advance(qx_reg, rx_reg, dvd_x_reg[MAGW-1:0], rem_x_reg, divisor_reg);
    assign adv_y    = advance(qy_reg, ry_reg, dvd_y_reg[MAGW-1:0], rem_y_reg, divisor_reg);
    assign mag_dx   = dx_reg[CB] ? (~dx_reg + MAGW'(1)) : dx_reg;
    assign mag_dy   = dy_reg[CB] ? (~dy_reg + MAGW'(1)) : dy_reg;
    assign pt_x     = neg_x_reg ? (prev_x_reg - qx_reg[CB-1:0]) : (prev_x_reg + qx_reg[CB-1:0]);
    assign pt_y     = neg_y_reg ? (prev_y_reg - qy_reg[CB-1:0]) : (prev_y_reg + qy_reg[CB-1:0]);
    assign half_div = {1'b0, divisor_reg[DSW-1:1]};
    assign slot_free = !out_valid_reg || point.ready;
    assign accept   = vertex.valid && (state_reg == S_IDLE);
    assign start    = vertex.starts_line || !have_prev_reg;

    // Piece count n (splits plus one) chosen when the search ends.
    always_comb
    begin
        if (t_reg == SPW'(MAX_SPLITS + 1))
        begin
            n_val = SPW'(MAX_SPLITS + 1);
        end
        else
        begin
            n_val = t_reg + SPW'(1);
        end
    end

    // Ports.
    assign vertex.ready         = (state_reg == S_IDLE);
    assign point.valid          = out_valid_reg;
    assign point.point_x        = out_x_reg;
    assign point.point_y        = out_y_reg;
    assign point.is_inserted    = out_ins_reg;
    assign point.last_of_run    = out_last_reg;
    assign point.splits_clamped = out_clamp_reg;

    // Sequencer and datapath next values.
    always_comb
    begin
        state_next     = state_reg;
        max_len_next   = cfg_wr_en ? cfg_wr_data : max_len_reg;
        have_prev_next = have_prev_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        out_valid_next = out_valid_reg && !point.ready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_ins_next   = out_ins_reg;
        out_last_next  = out_last_reg;
        out_clamp_next = out_clamp_reg;
        dig_next       = dig_reg;
        div_cnt_next   = div_cnt_reg;
        t_next         = t_reg;
        splits_next    = splits_reg;
        k_next         = k_reg;
        clamped_next   = clamped_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        mag_x_next     = mag_x_reg;
        mag_y_next     = mag_y_reg;
        neg_x_next     = neg_x_reg;
        neg_y_next     = neg_y_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        prod_next      = prod_reg;
        d2_next        = d2_reg;
        l2_next        = l2_reg;
        sq_next        = sq_reg;
        inc_next       = inc_reg;
        divisor_next   = divisor_reg;
        dvd_x_next     = dvd_x_reg;
        dvd_y_next     = dvd_y_reg;
        rem_x_next     = rem_x_reg;
        rem_y_next     = rem_y_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cur_x_next   = vertex.vertex_x;
                    cur_y_next   = vertex.vertex_y;
                    dx_next      = {vertex.vertex_x[CB-1], vertex.vertex_x}
                                   - {prev_x_reg[CB-1], prev_x_reg};
                    dy_next      = {vertex.vertex_y[CB-1], vertex.vertex_y}
                                   - {prev_y_reg[CB-1], prev_y_reg};
                    splits_next  = '0;
                    clamped_next = 1'b0;
                    k_next       = SPW'(1);
                    state_next   = start ? S_EMIT : S_MAG;
                end
            end

            // Take magnitudes and start squaring the easting difference.
            S_MAG:
            begin
                mag_x_next  = mag_dx;
                mag_y_next  = mag_dy;
                neg_x_next  = dx_reg[CB];
                neg_y_next  = dy_reg[CB];
                mcand_next  = MW'(mag_dx);
                mplier_next = MPW'(mag_dx);
                prod_next   = '0;
                dig_next    = '0;
                state_next  = S_SQ_X;
            end

            // Three squarings on the shared multiplier: dx, dy and the length limit.
            S_SQ_X, S_SQ_Y, S_SQ_L:
            begin
                prod_next   = prod_step;
                mplier_next = mplier_reg << DIGIT_BITS;
                dig_next    = dig_reg + DGW'(1);
                if (last_digit)
                begin
                    prod_next = '0;
                    dig_next  = '0;
                    if (state_reg == S_SQ_X)
                    begin
                        d2_next     = CMPW'(prod_step);
                        mcand_next  = MW'(mag_y_reg);
                        mplier_next = MPW'(mag_y_reg);
                        state_next  = S_SQ_Y;
                    end
                    else if (state_reg == S_SQ_Y)
                    begin
                        sq_next     = CMPW'(prod_step);
                        mcand_next  = MW'(max_len_reg);
                        mplier_next = MPW'(max_len_reg);
                        state_next  = S_SQ_L;
                    end
                    else
                    begin
                        l2_next    = CMPW'(prod_step);
                        d2_next    = d2_reg + sq_reg;
                        state_next = S_CHECK;
                    end
                end
            end

            // Only segments longer than the limit are split.
            S_CHECK:
            begin
                if (d2_reg > l2_reg)
                begin
                    t_next     = SPW'(1);
                    sq_next    = l2_reg << 2;
                    inc_next   = (l2_reg << 2) + l2_reg;
                    state_next = S_SEARCH;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end

            // Walk (t*L)^2 upwards by adding odd multiples of L^2.
            S_SEARCH:
            begin
                if ((t_reg != SPW'(MAX_SPLITS + 1)) && (sq_reg <= d2_reg))
                begin
                    t_next   = t_reg + SPW'(1);
                    sq_next  = sq_reg + inc_reg;
                    inc_next = inc_reg + (l2_reg << 1);
                end
                else
                begin
                    splits_next  = n_val - SPW'(1);
                    clamped_next = (t_reg == SPW'(MAX_SPLITS + 1));
                    divisor_next = {n_val, 1'b0};
                    dvd_x_next   = {mag_x_reg, 1'b0};
                    dvd_y_next   = {mag_y_reg, 1'b0};
                    rem_x_next   = '0;
                    rem_y_next   = '0;
                    div_cnt_next = '0;
                    state_next   = S_DIVIDE;
                end
            end

            // Divide 2|d| by 2n on both axes, one bit per cycle.
            S_DIVIDE:
            begin
                dvd_x_next   = div_x[DVW+DSW-1:DSW];
                rem_x_next   = div_x[DSW-1:0];
                dvd_y_next   = div_y[DVW+DSW-1:DSW];
                rem_y_next   = div_y[DSW-1:0];
                div_cnt_next = div_cnt_reg + DCW'(1);
                if (div_cnt_reg == DCW'(DVW - 1))
                begin
                    qx_next    = '0;
                    qy_next    = '0;
                    rx_next    = half_div;
                    ry_next    = half_div;
                    state_next = S_STEP;
                end
            end

            // Advance to the first inserted point.
            S_STEP:
            begin
                qx_next    = adv_x[MAGW+DSW-1:DSW];
                rx_next    = adv_x[DSW-1:0];
                qy_next    = adv_y[MAGW+DSW-1:DSW];
                ry_next    = adv_y[DSW-1:0];
                state_next = S_EMIT;
            end

            // One point per free output slot, the original vertex last.
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_clamp_next = clamped_reg;
                    if (k_reg <= splits_reg)
                    begin
                        out_x_next    = pt_x;
                        out_y_next    = pt_y;
                        out_ins_next  = 1'b1;
                        out_last_next = 1'b0;
                        qx_next       = adv_x[MAGW+DSW-1:DSW];
                        rx_next       = adv_x[DSW-1:0];
                        qy_next       = adv_y[MAGW+DSW-1:DSW];
                        ry_next       = adv_y[DSW-1:0];
                        k_next        = k_reg + SPW'(1);
                    end
                    else
                    begin
                        out_x_next     = cur_x_reg;
                        out_y_next     = cur_y_reg;
                        out_ins_next   = 1'b0;
                        out_last_next  = 1'b1;
                        prev_x_next    = cur_x_reg;
                        prev_y_next    = cur_y_reg;
                        have_prev_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, control and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            max_len_reg   <= MAX_LEN_RESET;
            have_prev_reg <= 1'b0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_ins_reg   <= 1'b0;
            out_last_reg  <= 1'b0;
            out_clamp_reg <= 1'b0;
            dig_reg       <= '0;
            div_cnt_reg   <= '0;
            t_reg         <= '0;
            splits_reg    <= '0;
            k_reg         <= '0;
            clamped_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            max_len_reg   <= max_len_next;
            have_prev_reg <= have_prev_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            out_valid_reg <= out_valid_next;
            out_x_reg     <= out_x_next;
            out_y_reg     <= out_y_next;
            out_ins_reg   <= out_ins_next;
            out_last_reg  <= out_last_next;
            out_clamp_reg <= out_clamp_next;
            dig_reg       <= dig_next;
            div_cnt_reg   <= div_cnt_next;
            t_reg         <= t_next;
            splits_reg    <= splits_next;
            k_reg         <= k_next;
            clamped_reg   <= clamped_next;
        end
    end

    // Arithmetic working registers; no reset needed.
    always_ff @(posedge clk)
    begin
        cur_x_reg   <= cur_x_next;
        cur_y_reg   <= cur_y_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        mag_x_reg   <= mag_x_next;
        mag_y_reg   <= mag_y_next;
        neg_x_reg   <= neg_x_next;
        neg_y_reg   <= neg_y_next;
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        prod_reg    <= prod_next;
        d2_reg      <= d2_next;
        l2_reg      <= l2_next;
        sq_reg      <= sq_next;
        inc_reg     <= inc_next;
        divisor_reg <= divisor_next;
        dvd_x_reg   <= dvd_x_next;
        dvd_y_reg   <= dvd_y_next;
        rem_x_reg   <= rem_x_next;
        rem_y_reg   <= rem_y_next;
        qx_reg      <= qx_next;
        qy_reg      <= qy_next;
        rx_reg      <= rx_next;
        ry_reg      <= ry_next;
    end

endmodule

// ===== bench/pseg_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the polyline segment densifier: watches the vertex, point and
// configuration ports, predicts every emitted point and compares it field by field.
// Depends on pseg_pkg and on the channel interfaces in pseg_if.sv.

module pseg_checker
    import pseg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int MAX_SPLITS = MAX_SPLITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    pseg_vertex_if              vertex,
    pseg_point_if               point,
    input  logic                cfg_wr_en,
    input  logic [LEN_BITS-1:0] cfg_wr_data,
    output int                  fail_count,
    output int                  points_owed
);

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   inserted;
        logic   last;
        logic   clamped;
    } point_t;

    // Points still owed by the block, oldest first.
    point_t              owed_points[$];
    point_t              want_point;
    point_t              got_point;
    logic [LEN_BITS-1:0] seg_limit;
    coord_t              last_x;
    coord_t              last_y;
    logic                have_last;
    int                  mismatches = 0;

    function automatic longint as_signed(coord_t c);
        longint v;
        v = $signed(c);
        return v;
    endfunction

    // Origin plus round(k * delta / n) on one axis; ties round away from zero.
    function automatic coord_t step_along(longint origin, longint delta, int k, int n);
        longint unsigned span;
        longint unsigned q;
        span = (delta < 0) ? longint'(-delta) : longint'(delta);
        span = span * longint'(k);
        q    = (2 * span + longint'(n)) / (2 * longint'(n));
        if (delta < 0)
        begin
            return coord_t'(origin - longint'(q));
        end
        return coord_t'(origin + longint'(q));
    endfunction

    // Works out the run of points one accepted vertex causes and queues them.
    function automatic void densify(coord_t cx, coord_t cy, logic start_flag);
        longint          px;
        longint          py;
        longint          dx;
        longint          dy;
        longint unsigned ax;
        longint unsigned ay;
        logic [127:0]    d2;
        logic [127:0]    lim;
        logic [127:0]    reach;
        int              splits;
        int              t;
        logic            clamped;
        point_t          p;
        splits  = 0;
        clamped = 1'b0;
        px = as_signed(last_x);
        py = as_signed(last_y);
        dx = as_signed(cx) - px;
        dy = as_signed(cy) - py;

        // Only a continuing segment is measured; a line start passes straight through.
        if (have_last && !start_flag)
        begin
            ax  = (dx < 0) ? longint'(-dx) : longint'(dx);
            ay  = (dy < 0) ? longint'(-dy) : longint'(dy);
            d2  = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
            lim = 128'(seg_limit);
            if (d2 > lim * lim)
            begin
                for (t = 1; t <= MAX_SPLITS; t++)
                begin
                    reach = lim * 128'(t);
                    if (reach * reach <= d2)
                        splits = t;
                end
                reach   = lim * 128'(MAX_SPLITS + 1);
                clamped = (reach * reach <= d2);
            end
        end

        // Evenly spaced interior points, then the vertex itself.
        for (t = 1; t <= splits; t++)
        begin
            p.x        = step_along(px, dx, t, splits + 1);
            p.y        = step_along(py, dy, t, splits + 1);
            p.inserted = 1'b1;
            p.last     = 1'b0;
            p.clamped  = clamped;
            owed_points.push_back(p);
        end
        p.x        = cx;
        p.y        = cy;
        p.inserted = 1'b0;
        p.last     = 1'b1;
        p.clamped  = clamped;
        owed_points.push_back(p);

        last_x    = cx;
        last_y    = cy;
        have_last = 1'b1;
    endfunction

    function automatic void report_field(string field, longint unsigned want,
                                         longint unsigned got);
        if (want != got)
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
    endfunction

    // Points are compared before the vertex of the same edge is queued, since no
    // point can be caused by a vertex accepted at that very edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owed_points.delete();
            seg_limit   = MAX_LEN_RESET;
            last_x      = '0;
            last_y      = '0;
            have_last   = 1'b0;
            fail_count  <= 0;
            points_owed <= 0;
        end
        else
        begin
            if (point.valid && point.ready)
            begin
                got_point.x        = point.point_x;
                got_point.y        = point.point_y;
                got_point.inserted = point.is_inserted;
                got_point.last     = point.last_of_run;
                got_point.clamped  = point.splits_clamped;
                if (owed_points.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: expected no point, got (%0h, %0h)", $time,
                             got_point.x, got_point.y);
                end
                else
                begin
                    want_point = owed_points.pop_front();
                    if (got_point !== want_point)
                    begin
                        mismatches++;
                        report_field("point_x", want_point.x, got_point.x);
                        report_field("point_y", want_point.y, got_point.y);
                        report_field("is_inserted", want_point.inserted,
                                     got_point.inserted);
                        report_field("last_of_run", want_point.last, got_point.last);
                        report_field("splits_clamped", want_point.clamped,
                                     got_point.clamped);
                    end
                end
            end

            if (vertex.valid && vertex.ready)
                densify(vertex.vertex_x, vertex.vertex_y, vertex.starts_line);

            if (cfg_wr_en)
                seg_limit = cfg_wr_data;

            fail_count  <= mismatches;
            points_owed <= owed_points.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Top of the densifier bench: clock, reset, vertex stimulus, point back-pressure,
// limit register writes and the verdict. Depends on pseg_pkg, pseg_if.sv and pseg_checker.

module tb;
    import pseg_pkg::*;

    localparam int CB          = COORD_BITS_DEF;
    localparam int RUN_LIMIT   = 20_000_000;
    localparam int DRAIN_EDGES = 60;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [LEN_BITS-1:0] cfg_wr_data;
    int                  fail_count;
    int                  points_owed;

    // Pacing switches: when set, that side never idles.
    bit                  src_steady;
    bit                  snk_steady;
    longint              seg_len;
    longint              tip_x;
    longint              tip_y;

    pseg_vertex_if #(.COORD_BITS(CB)) vertex_ch ();
    pseg_point_if  #(.COORD_BITS(CB)) point_ch ();

    polyline_segment_densifier_top #(
        .COORD_BITS (CB),
        .MAX_SPLITS (MAX_SPLITS_DEF)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .vertex      (vertex_ch),
        .point       (point_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    pseg_checker #(
        .COORD_BITS (CB),
        .MAX_SPLITS (MAX_SPLITS_DEF)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .vertex      (vertex_ch),
        .point       (point_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fail_count  (fail_count),
        .points_owed (points_owed)
    );

    always #5 clk = ~clk;

    // Hard stop in case the block hangs.
    initial
    begin
        #(RUN_LIMIT);
        $display("** polyline_segment_densifier_top: FAILED **");
        $finish;
    end

    // Point side: a random stall before each transfer.
    initial
    begin
        int unsigned hold;
        point_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = snk_steady ? 0 : $urandom_range(11);
            if (hold != 0)
            begin
                point_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            point_ch.ready <= 1'b1;
            do @(posedge clk); while (!(point_ch.valid && point_ch.ready));
        end
    end

    // Offers one vertex after a random gap and returns at the edge of its transfer.
    task automatic put_vertex(longint x, longint y, logic start);
        int unsigned   gap;
        logic [CB-1:0] vx;
        logic [CB-1:0] vy;
        vx  = x[CB-1:0];
        vy  = y[CB-1:0];
        gap = src_steady ? 0 : $urandom_range(11);
        if (gap != 0)
        begin
            vertex_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vertex_ch.valid       <= 1'b1;
        vertex_ch.vertex_x    <= vx;
        vertex_ch.vertex_y    <= vy;
        vertex_ch.starts_line <= start;
        do @(posedge clk); while (!(vertex_ch.valid && vertex_ch.ready));
        tip_x = $signed(vx);
        tip_y = $signed(vy);
    endtask

    task automatic put_step(longint dx, longint dy);
        put_vertex(tip_x + dx, tip_y + dy, 1'b0);
    endtask

    // Writes the segment limit once the block has delivered everything owed.
    task automatic set_limit(logic [LEN_BITS-1:0] value);
        vertex_ch.valid <= 1'b0;
        do @(posedge clk); while (points_owed != 0);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        seg_len = value;
    endtask

    // One axis of a segment, scaled to the current limit so that every split count
    // from none to saturation turns up.
    function automatic longint draw_step();
        longint      span;
        longint      times;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            // Exact multiples of the limit sit on the split boundaries.
            times = $urandom_range(70);
            span  = seg_len * times;
            return (pick < 5) ? span : -span;
        end
        else if (pick < 35)
            span = seg_len;
        else if (pick < 75)
        begin
            times = $urandom_range(20, 1);
            span  = seg_len * times;
        end
        else if (pick < 92)
        begin
            times = $urandom_range(80, 20);
            span  = seg_len * times;
        end
        else
            span = 64'h7fff_ffff;
        span = span + longint'($urandom_range(255));
        draw_step = longint'($urandom) % (span + 1);
        if ($urandom_range(1) != 0)
            draw_step = -draw_step;
    endfunction

    // Mostly whole polylines with random content, with some stray vertices between.
    task automatic run_lines(int count);
        int          left;
        int          run_len;
        int          i;
        int unsigned pick;
        longint      near_x;
        longint      near_y;
        left = count;
        while (left > 0)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                put_vertex($urandom, $urandom, 1'($urandom_range(1)));
                left--;
            end
            else
            begin
                near_x = longint'($urandom_range(2 ** 21)) - 2 ** 20;
                near_y = longint'($urandom_range(2 ** 21)) - 2 ** 20;
                if (pick < 50)
                    put_vertex($urandom, $urandom, 1'b1);
                else
                    put_vertex(near_x, near_y, (pick < 55) ? 1'b0 : 1'b1);
                left--;
                run_len = $urandom_range(8, 1);
                for (i = 0; i < run_len && left > 0; i++)
                begin
                    pick = $urandom_range(99);
                    if (pick < 5)
                        put_step(0, 0);
                    else if (pick < 20)
                        put_step(draw_step(), 0);
                    else
                        put_step(draw_step(), draw_step());
                    left--;
                end
            end
        end
    endtask

    // Hand-picked vertices at the reset limit of 80 m.
    task automatic run_directed();
        // First vertex after reset is a line start whatever its flag says.
        put_vertex(64, -64, 1'b0);
        // Zero length, then exactly the limit: nothing inserted.
        put_step(0, 0);
        put_step(5120, 0);
        // Just over the limit: one midpoint, halfway ties in both directions.
        put_step(5121, 0);
        put_step(-5121, 0);
        // A 3-4-5 triangle under the limit, then one ten times larger.
        put_step(-3000, -4000);
        put_step(30000, 40000);
        // Whole multiples of the limit, up to and past saturation.
        put_step(5120 * 10, 0);
        put_step(0, -5120 * 63);
        put_step(0, 5120 * 64);
        put_step(-7, 5120 * 64 + 11);
        // Corners of the coordinate range.
        put_vertex(-(2 ** 31), -(2 ** 31), 1'b1);
        put_vertex(2 ** 31 - 1, 2 ** 31 - 1, 1'b0);
        put_vertex(-(2 ** 31), 2 ** 31 - 1, 1'b0);
        put_vertex(2 ** 31 - 1, -(2 ** 31), 1'b0);
        // A line start far from the previous vertex passes unchanged.
        put_vertex(0, 0, 1'b1);
        put_vertex(-1, -1, 1'b1);
        put_step(-15364, 7);
        put_step(5121 * 3, -5121 * 2);
        put_vertex(tip_x + 3, tip_y, 1'b1);
        put_step(-(5120 * 20 + 1), -(5120 * 20 + 1));
    endtask

    initial
    begin
        rst_n                 <= 1'b0;
        cfg_wr_en             <= 1'b0;
        cfg_wr_data           <= '0;
        vertex_ch.valid       <= 1'b0;
        vertex_ch.vertex_x    <= '0;
        vertex_ch.vertex_y    <= '0;
        vertex_ch.starts_line <= 1'b0;
        src_steady = 1'b0;
        snk_steady = 1'b0;
        seg_len    = MAX_LEN_RESET;
        tip_x      = 0;
        tip_y      = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        set_limit(MAX_LEN_RESET);
        run_lines(50);

        // Smallest legal limit: nearly every segment saturates.
        snk_steady = 1'b1;
        set_limit(20'd1);
        run_lines(40);

        // Largest limit.
        snk_steady = 1'b0;
        src_steady = 1'b1;
        set_limit('1);
        run_lines(50);

        // Zero limit: any nonzero segment saturates.
        snk_steady = 1'b1;
        set_limit('0);
        run_lines(30);

        src_steady = 1'b0;
        snk_steady = 1'b0;
        set_limit(LEN_BITS'($urandom_range(4000, 1)));
        run_lines(60);

        set_limit(LEN_BITS'($urandom_range(2 ** LEN_BITS - 1, 1)));
        run_lines(70);

        // Drain, then leave time for any stray point to show up.
        vertex_ch.valid <= 1'b0;
        do @(posedge clk); while (points_owed != 0);
        repeat (DRAIN_EDGES) @(posedge clk);
        #1;
        if (fail_count == 0 && points_owed == 0)
            $display("** polyline_segment_densifier_top: PASSED **");
        else
            $display("** polyline_segment_densifier_top: FAILED **");
        $finish;
    end

endmodule
